// ----- hdl/soa_pkg.sv -----
package soa_pkg;

    localparam int NUM_FRAMES  = 16;
    localparam int MAX_OBJECTS = 256;
    localparam int FRAME_W     = 4;
    localparam int LINK_W      = 5;
    localparam int OBJ_W       = 8;
    localparam int COUNT_W     = 9;
    localparam int CHAIN_AW    = FRAME_W + OBJ_W;

    localparam logic [LINK_W-1:0]  LINK_NIL  = LINK_W'(NUM_FRAMES);
    localparam logic [COUNT_W-1:0] CHAIN_END = 9'd511;
    localparam logic [COUNT_W-1:0] OPS_RESET = 9'd256;
    localparam logic [COUNT_W-1:0] OPS_MAX   = COUNT_W'(MAX_OBJECTS);

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_SHRINK = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        L_FULL    = 2'd0,
        L_PARTIAL = 2'd1,
        L_FREE    = 2'd2
    } list_t;

    typedef struct packed {
        logic [1:0]         tag;
        logic [LINK_W-1:0]  fwd;
        logic [LINK_W-1:0]  bwd;
        logic [COUNT_W-1:0] head;
    } frame_rec_t;

    localparam int REC_W = $bits(frame_rec_t);

endpackage

// ----- hdl/soa_ram.sv -----
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/slab_object_allocator_core.sv -----
// Channel  | Ports                                  | Direction
// request  | s_valid/s_ready, s_mode, s_slab_index, | in
//          | s_object_index                         |
// result   | m_valid/m_ready, m_status,             | out
//          | m_granted_slab, m_granted_object,      |
//          | m_released_count                       |
// config   | APB: psel/penable/pwrite/paddr/pwdata  | in/out
//
// One request at a time. Alloc and free do the list unlink/relink
// read-modify-writes on the frame-record RAM one at a time. Grow does one
// chain RAM write per object. Shrink walks the free list one released slab
// at a time. A new request is taken while the previous result waits in the
// output register. Reset is synchronous, active low; frame records and chain
// links are left uninitialized, only taken bits, use counts, list heads and
// the pending and valid flags are cleared.
module slab_object_allocator_core
    import soa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_slab_index,
    input  logic [7:0]  s_object_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_granted_slab,
    output logic [7:0]  m_granted_object,
    output logic [4:0]  m_released_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_GROW_FILL = 16'h0002,
        S_GROW_REC  = 16'h0004,
        S_F_RD      = 16'h0008,
        S_F_CHK     = 16'h0010,
        S_RM_BW     = 16'h0020,
        S_RM_BW_WR  = 16'h0040,
        S_RM_FW     = 16'h0080,
        S_RM_FW_WR  = 16'h0100,
        S_CHAIN     = 16'h0200,
        S_CH_DAT    = 16'h0400,
        S_PUSH      = 16'h0800,
        S_PUSH_RD   = 16'h1000,
        S_PUSH_WR   = 16'h2000,
        S_SH_STEP   = 16'h4000,
        S_SH_DAT    = 16'h8000
    } state_t;

    // result waits in rs_* with a pending flag until the output register is free
    state_t state_reg, state_next;

    logic [COUNT_W-1:0] ops_reg, ops_next;
    logic [COUNT_W-1:0] n_eff;

    logic [NUM_FRAMES-1:0] taken_reg, taken_next;
    logic [COUNT_W-1:0]    used_reg [NUM_FRAMES];
    logic [COUNT_W-1:0]    used_next [NUM_FRAMES];
    logic [LINK_W-1:0]     heads_reg [3];
    logic [LINK_W-1:0]     heads_next [3];

    logic [1:0]         mode_reg, mode_next;
    logic [OBJ_W-1:0]   obj_reg, obj_next;
    logic [LINK_W-1:0]  cur_reg, cur_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]         tag_reg, tag_next;
    logic [LINK_W-1:0]  fwd_reg, fwd_next;
    logic [LINK_W-1:0]  bwd_reg, bwd_next;
    logic [COUNT_W-1:0] head_reg, head_next;
    logic [COUNT_W-1:0] nhead_reg, nhead_next;
    logic [1:0]         plist_reg, plist_next;
    logic [4:0]         guard_reg, guard_next;

    // pending result, waiting for the output register
    logic               pend_reg, pend_next;
    logic [1:0]         rs_status_reg, rs_status_next;
    logic [3:0]         rs_slab_reg, rs_slab_next;
    logic [7:0]         rs_obj_reg, rs_obj_next;
    logic [4:0]         rs_rc_reg, rs_rc_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [3:0]  m_slab_reg, m_slab_next;
    logic [7:0]  m_obj_reg, m_obj_next;
    logic [4:0]  m_rc_reg, m_rc_next;

    // frame record RAM
    logic       fr_we, fr_re;
    logic [FRAME_W-1:0] fr_waddr, fr_raddr;
    frame_rec_t fr_wdata, fr_rdata;
    logic [REC_W-1:0] fr_rdata_raw;

    // object chain RAM
    logic                ch_we, ch_re;
    logic [CHAIN_AW-1:0] ch_waddr, ch_raddr;
    logic [COUNT_W-1:0]  ch_wdata, ch_rdata;

    logic               free_found;
    logic [FRAME_W-1:0] free_frame;
    logic [FRAME_W-1:0] cur_f;
    logic [COUNT_W-1:0] used_cur;
    logic               cfg_wr;

    soa_ram #(.WIDTH(REC_W), .DEPTH(NUM_FRAMES)) u_frame_ram (
        .aclk  (aclk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata_raw)
    );
    assign fr_rdata = frame_rec_t'(fr_rdata_raw);

    soa_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_FRAMES * MAX_OBJECTS)) u_chain_ram (
        .aclk  (aclk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (ch_re),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    // effective objects per slab, clamped to 1..MAX_OBJECTS
    always_comb begin
        if (ops_reg == '0) begin
            n_eff = COUNT_W'(1);
        end else if (ops_reg > OPS_MAX) begin
            n_eff = OPS_MAX;
        end else begin
            n_eff = ops_reg;
        end
    end

    // lowest untaken frame
    always_comb begin
        free_found = 1'b0;
        free_frame = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (!taken_reg[i]) begin
                free_found = 1'b1;
                free_frame = FRAME_W'(i);
            end
        end
    end

    assign cur_f    = cur_reg[FRAME_W-1:0];
    assign used_cur = used_reg[cur_f];

    // APB side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? {23'd0, ops_reg} : 32'd0;
    assign ops_next = (cfg_wr && paddr[2] == 1'b0) ? pwdata[COUNT_W-1:0] : ops_reg;

    assign s_ready = (state_reg == S_IDLE) && !pend_reg;

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_slab   = m_slab_reg;
    assign m_granted_object = m_obj_reg;
    assign m_released_count = m_rc_reg;

    always_comb begin
        state_next     = state_reg;
        taken_next     = taken_reg;
        used_next      = used_reg;
        heads_next     = heads_reg;
        mode_next      = mode_reg;
        obj_next       = obj_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        tag_next       = tag_reg;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        head_next      = head_reg;
        nhead_next     = nhead_reg;
        plist_next     = plist_reg;
        guard_next     = guard_reg;
        pend_next      = pend_reg;
        rs_status_next = rs_status_reg;
        rs_slab_next   = rs_slab_reg;
        rs_obj_next    = rs_obj_reg;
        rs_rc_next     = rs_rc_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_slab_next    = m_slab_reg;
        m_obj_next     = m_obj_reg;
        m_rc_next      = m_rc_reg;

        fr_we    = 1'b0;
        fr_waddr = cur_f;
        fr_wdata = fr_rdata;
        fr_re    = 1'b0;
        fr_raddr = cur_f;
        ch_we    = 1'b0;
        ch_waddr = {cur_f, cnt_reg[OBJ_W-1:0]};
        ch_wdata = '0;
        ch_re    = 1'b0;
        ch_raddr = {cur_f, head_reg[OBJ_W-1:0]};

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pend_reg && (!m_valid_reg || m_ready)) begin
            m_valid_next  = 1'b1;
            m_status_next = rs_status_reg;
            m_slab_next   = rs_slab_reg;
            m_obj_next    = rs_obj_reg;
            m_rc_next     = rs_rc_reg;
            pend_next     = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && !pend_reg) begin
                    mode_next      = s_mode;
                    obj_next       = s_object_index;
                    cur_next       = {1'b0, s_slab_index};
                    rs_status_next = ST_OK;
                    rs_slab_next   = '0;
                    rs_obj_next    = '0;
                    rs_rc_next     = '0;
                    unique case (mode_t'(s_mode))
                        MODE_ALLOC: begin
                            if (heads_reg[L_PARTIAL] != LINK_NIL) begin
                                cur_next   = heads_reg[L_PARTIAL];
                                state_next = S_F_RD;
                            end else if (heads_reg[L_FREE] != LINK_NIL) begin
                                cur_next   = heads_reg[L_FREE];
                                state_next = S_F_RD;
                            end else if (free_found) begin
                                cur_next   = {1'b0, free_frame};
                                cnt_next   = '0;
                                state_next = S_GROW_FILL;
                            end else begin
                                rs_status_next = ST_NO_FRAME;
                                pend_next      = 1'b1;
                            end
                        end
                        MODE_FREE: begin
                            if (!taken_reg[s_slab_index] ||
                                {1'b0, s_object_index} >= n_eff ||
                                used_reg[s_slab_index] == '0) begin
                                rs_status_next = ST_REJECT;
                                pend_next      = 1'b1;
                            end else begin
                                state_next = S_F_RD;
                            end
                        end
                        MODE_SHRINK: begin
                            cur_next   = heads_reg[L_FREE];
                            guard_next = '0;
                            state_next = S_SH_STEP;
                        end
                        default: begin
                            pend_next = 1'b1;
                        end
                    endcase
                end
            end
            S_GROW_FILL: begin
                ch_we    = 1'b1;
                ch_waddr = {cur_f, cnt_reg[OBJ_W-1:0]};
                ch_wdata = (cnt_reg + 1'b1 == n_eff) ? CHAIN_END : cnt_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == n_eff) begin
                    state_next = S_GROW_REC;
                end
            end
            S_GROW_REC: begin
                fr_we             = 1'b1;
                fr_waddr          = cur_f;
                fr_wdata          = '{tag: L_FREE, fwd: LINK_NIL, bwd: LINK_NIL, head: '0};
                taken_next[cur_f] = 1'b1;
                used_next[cur_f]  = '0;
                heads_next[L_FREE] = cur_reg;
                state_next        = S_F_RD;
            end
            S_F_RD: begin
                fr_re      = 1'b1;
                fr_raddr   = cur_f;
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                tag_next  = fr_rdata.tag;
                fwd_next  = fr_rdata.fwd;
                bwd_next  = fr_rdata.bwd;
                head_next = fr_rdata.head;
                if (mode_reg == MODE_ALLOC &&
                    (fr_rdata.head >= n_eff || used_cur >= n_eff)) begin
                    rs_status_next = ST_NO_FRAME;
                    pend_next      = 1'b1;
                    state_next     = S_IDLE;
                end else begin
                    state_next = S_RM_BW;
                end
            end
            S_RM_BW: begin
                if (bwd_reg < LINK_NIL) begin
                    fr_re      = 1'b1;
                    fr_raddr   = bwd_reg[FRAME_W-1:0];
                    state_next = S_RM_BW_WR;
                end else begin
                    if (tag_reg != 2'd3) begin
                        heads_next[tag_reg] = fwd_reg;
                    end
                    state_next = S_RM_FW;
                end
            end
            S_RM_BW_WR: begin
                fr_we        = 1'b1;
                fr_waddr     = bwd_reg[FRAME_W-1:0];
                fr_wdata     = fr_rdata;
                fr_wdata.fwd = fwd_reg;
                state_next   = S_RM_FW;
            end
            S_RM_FW: begin
                if (fwd_reg < LINK_NIL) begin
                    fr_re      = 1'b1;
                    fr_raddr   = fwd_reg[FRAME_W-1:0];
                    state_next = S_RM_FW_WR;
                end else begin
                    state_next = S_CHAIN;
                end
            end
            S_RM_FW_WR: begin
                fr_we        = 1'b1;
                fr_waddr     = fwd_reg[FRAME_W-1:0];
                fr_wdata     = fr_rdata;
                fr_wdata.bwd = bwd_reg;
                state_next   = S_CHAIN;
            end
            S_CHAIN: begin
                if (mode_reg == MODE_ALLOC) begin
                    ch_re      = 1'b1;
                    ch_raddr   = {cur_f, head_reg[OBJ_W-1:0]};
                    state_next = S_CH_DAT;
                end else begin
                    ch_we            = 1'b1;
                    ch_waddr         = {cur_f, obj_reg};
                    ch_wdata         = head_reg;
                    nhead_next       = {1'b0, obj_reg};
                    used_next[cur_f] = used_cur - 1'b1;
                    plist_next       = (used_cur == COUNT_W'(1)) ? L_FREE : L_PARTIAL;
                    state_next       = S_PUSH;
                end
            end
            S_CH_DAT: begin
                nhead_next       = ch_rdata;
                used_next[cur_f] = used_cur + 1'b1;
                plist_next       = (used_cur + 1'b1 >= n_eff) ? L_FULL : L_PARTIAL;
                rs_slab_next     = cur_f;
                rs_obj_next      = head_reg[OBJ_W-1:0];
                state_next       = S_PUSH;
            end
            S_PUSH: begin
                fr_we    = 1'b1;
                fr_waddr = cur_f;
                fr_wdata = '{tag: plist_reg, fwd: heads_reg[plist_reg],
                             bwd: LINK_NIL, head: nhead_reg};
                fwd_next = heads_reg[plist_reg];
                heads_next[plist_reg] = cur_reg;
                if (heads_reg[plist_reg] < LINK_NIL) begin
                    state_next = S_PUSH_RD;
                end else begin
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PUSH_RD: begin
                fr_re      = 1'b1;
                fr_raddr   = fwd_reg[FRAME_W-1:0];
                state_next = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                fr_we        = 1'b1;
                fr_waddr     = fwd_reg[FRAME_W-1:0];
                fr_wdata     = fr_rdata;
                fr_wdata.bwd = cur_reg;
                pend_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_SH_STEP: begin
                if (cur_reg < LINK_NIL && guard_reg < 5'(NUM_FRAMES)) begin
                    fr_re      = 1'b1;
                    fr_raddr   = cur_f;
                    state_next = S_SH_DAT;
                end else begin
                    heads_next[L_FREE] = LINK_NIL;
                    rs_rc_next         = guard_reg;
                    pend_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_SH_DAT: begin
                taken_next[cur_f] = 1'b0;
                used_next[cur_f]  = '0;
                guard_next        = guard_reg + 1'b1;
                cur_next          = fr_rdata.fwd;
                state_next        = S_SH_STEP;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ops_reg     <= OPS_RESET;
            taken_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                used_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                heads_reg[i] <= LINK_NIL;
            end
        end else begin
            state_reg   <= state_next;
            ops_reg     <= ops_next;
            taken_reg   <= taken_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            used_reg    <= used_next;
            heads_reg   <= heads_next;
        end
        mode_reg      <= mode_next;
        obj_reg       <= obj_next;
        cur_reg       <= cur_next;
        cnt_reg       <= cnt_next;
        tag_reg       <= tag_next;
        fwd_reg       <= fwd_next;
        bwd_reg       <= bwd_next;
        head_reg      <= head_next;
        nhead_reg     <= nhead_next;
        plist_reg     <= plist_next;
        guard_reg     <= guard_next;
        rs_status_reg <= rs_status_next;
        rs_slab_reg   <= rs_slab_next;
        rs_obj_reg    <= rs_obj_next;
        rs_rc_reg     <= rs_rc_next;
        m_status_reg  <= m_status_next;
        m_slab_reg    <= m_slab_next;
        m_obj_reg     <= m_obj_next;
        m_rc_reg      <= m_rc_next;
    end

`ifndef SYNTHESIS
    a_grow_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_GROW_REC |=> taken_reg[$past(cur_f)])
        else $error("grown frame not marked taken");

    a_guard_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        guard_reg <= 5'(NUM_FRAMES) || state_reg == S_IDLE)
        else $error("shrink walk overran frame count");

    a_free_head_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && heads_reg[L_FREE] != LINK_NIL
        |-> taken_reg[heads_reg[L_FREE][FRAME_W-1:0]])
        else $error("free list head is not a taken frame");

    a_partial_head_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && heads_reg[L_PARTIAL] != LINK_NIL
        |-> taken_reg[heads_reg[L_PARTIAL][FRAME_W-1:0]])
        else $error("partial list head is not a taken frame");

    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !s_ready)
        else $error("request accepted over an undelivered result");
`endif

endmodule
